// File: src/sreg_pkg.sv
// Shared types, codes and the microcode store for the session registration table.
package sreg_pkg;

   // Default number of session slots.
   localparam int SESSIONS_DEFAULT = 16;

   // Fixed field widths.
   localparam int FUNC_W   = 3;
   localparam int SOCK_W   = 16;
   localparam int HANDLE_W = 32;
   localparam int VER_W    = 16;
   localparam int OPTS_W   = 16;
   localparam int STATUS_W = 3;
   localparam int HOUT_W   = 5;
   localparam int PC_W     = 5;

   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [PC_W-1:0]   pc_type;

   // Request function codes.
   localparam func_type FN_REGISTER   = 3'd0;
   localparam func_type FN_UNREGISTER = 3'd1;
   localparam func_type FN_CHECK      = 3'd2;
   localparam func_type FN_CLOSE      = 3'd3;
   localparam func_type FN_CLEAR_ALL  = 3'd4;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_CMD    = 3'd1,
      ST_NO_MEM     = 3'd2,
      ST_BAD_PROTO  = 3'd3,
      ST_BAD_HANDLE = 3'd4
   } status_type;

   // How the step counter moves on.
   typedef enum logic [2:0] {
      J_NEXT,
      J_GOTO,
      J_COND,
      J_SCAN,
      J_DISPATCH
   } jmp_type;

   // Condition tested by a conditional or scanning step.
   typedef enum logic [2:0] {
      C_NONE,
      C_NOT_START,
      C_BAD_PROTO,
      C_BAD_HANDLE,
      C_MATCH,
      C_NO_FREE
   } cond_type;

   // Action on the slot table.
   typedef enum logic [2:0] {
      A_NONE,
      A_NOTE_FREE,
      A_WRITE,
      A_FREE_IDX,
      A_FREE_HANDLE,
      A_CLEAR_ALL
   } act_type;

   // Source of the handle in a result.
   typedef enum logic [1:0] {
      H_ZERO,
      H_IDX,
      H_FREE
   } hsel_type;

   // One control word of the program.
   typedef struct packed {
      jmp_type    jmp;
      cond_type   cond;
      pc_type     target;
      logic       clr;
      act_type    act;
      logic       emit;
      status_type status;
      hsel_type   hsel;
      logic       sopen;
   } ctl_word_type;

   // Datapath flags seen by the sequencer.
   typedef struct packed {
      logic not_start;
      logic bad_proto;
      logic bad_handle;
      logic match;
      logic no_free;
      logic last;
   } flags_type;

   // Sequencer outputs to the datapath.
   typedef struct packed {
      pc_type       pc;
      ctl_word_type word;
      logic         idx_inc;
   } ctl_type;

   // Program step addresses.
   localparam pc_type STEP_IDLE           = 5'd0;
   localparam pc_type STEP_DISPATCH       = 5'd1;
   localparam pc_type STEP_REG_CHK        = 5'd2;
   localparam pc_type STEP_REG_SCAN       = 5'd3;
   localparam pc_type STEP_REG_FREE_TEST  = 5'd4;
   localparam pc_type STEP_REG_COMMIT     = 5'd5;
   localparam pc_type STEP_RSP_DUP        = 5'd6;
   localparam pc_type STEP_RSP_NOMEM      = 5'd7;
   localparam pc_type STEP_UNREG_CHK      = 5'd8;
   localparam pc_type STEP_UNREG_DO       = 5'd9;
   localparam pc_type STEP_CHECK_CHK      = 5'd10;
   localparam pc_type STEP_CHECK_OPEN     = 5'd11;
   localparam pc_type STEP_CLOSE_SCAN     = 5'd12;
   localparam pc_type STEP_RSP_OK         = 5'd13;
   localparam pc_type STEP_CLOSE_FREE     = 5'd14;
   localparam pc_type STEP_CLEAR_ALL      = 5'd15;
   localparam pc_type STEP_RSP_BAD_CMD    = 5'd16;
   localparam pc_type STEP_RSP_BAD_PROTO  = 5'd17;
   localparam pc_type STEP_RSP_BAD_HANDLE = 5'd18;

   // Builds one control word.
   function automatic ctl_word_type uw(jmp_type jmp, cond_type cond, pc_type target,
                                       logic clr, act_type act, logic emit,
                                       status_type status, hsel_type hsel, logic sopen);
      ctl_word_type w;
      w.jmp    = jmp;
      w.cond   = cond;
      w.target = target;
      w.clr    = clr;
      w.act    = act;
      w.emit   = emit;
      w.status = status;
      w.hsel   = hsel;
      w.sopen  = sopen;
      return w;
   endfunction

   // A step that gives a result and returns to idle.
   function automatic ctl_word_type rsp(act_type act, status_type status, hsel_type hsel,
                                        logic sopen);
      return uw(J_GOTO, C_NONE, STEP_IDLE, 1'b0, act, 1'b1, status, hsel, sopen);
   endfunction

   // The control program.
   function automatic ctl_word_type ucode_rom(pc_type pc);
      ctl_word_type w;
      case (pc)
         STEP_IDLE:
            w = uw(J_COND, C_NOT_START, STEP_IDLE, 1'b1, A_NONE, 1'b0, ST_OK, H_ZERO, 1'b0);
         STEP_DISPATCH:
            w = uw(J_DISPATCH, C_NONE, STEP_IDLE, 1'b0, A_NONE, 1'b0, ST_OK, H_ZERO, 1'b0);
         STEP_REG_CHK:
            w = uw(J_COND, C_BAD_PROTO, STEP_RSP_BAD_PROTO, 1'b0, A_NONE, 1'b0, ST_OK,
                   H_ZERO, 1'b0);
         STEP_REG_SCAN:
            w = uw(J_SCAN, C_MATCH, STEP_RSP_DUP, 1'b0, A_NOTE_FREE, 1'b0, ST_OK,
                   H_ZERO, 1'b0);
         STEP_REG_FREE_TEST:
            w = uw(J_COND, C_NO_FREE, STEP_RSP_NOMEM, 1'b0, A_NONE, 1'b0, ST_OK,
                   H_ZERO, 1'b0);
         STEP_REG_COMMIT:     w = rsp(A_WRITE, ST_OK, H_FREE, 1'b0);
         STEP_RSP_DUP:        w = rsp(A_NONE, ST_BAD_CMD, H_IDX, 1'b0);
         STEP_RSP_NOMEM:      w = rsp(A_NONE, ST_NO_MEM, H_ZERO, 1'b0);
         STEP_UNREG_CHK:
            w = uw(J_COND, C_BAD_HANDLE, STEP_RSP_BAD_HANDLE, 1'b0, A_NONE, 1'b0, ST_OK,
                   H_ZERO, 1'b0);
         STEP_UNREG_DO:       w = rsp(A_FREE_HANDLE, ST_OK, H_ZERO, 1'b0);
         STEP_CHECK_CHK:
            w = uw(J_COND, C_BAD_HANDLE, STEP_RSP_BAD_HANDLE, 1'b0, A_NONE, 1'b0, ST_OK,
                   H_ZERO, 1'b0);
         STEP_CHECK_OPEN:     w = rsp(A_NONE, ST_OK, H_ZERO, 1'b1);
         STEP_CLOSE_SCAN:
            w = uw(J_SCAN, C_MATCH, STEP_CLOSE_FREE, 1'b0, A_NONE, 1'b0, ST_OK,
                   H_ZERO, 1'b0);
         STEP_RSP_OK:         w = rsp(A_NONE, ST_OK, H_ZERO, 1'b0);
         STEP_CLOSE_FREE:     w = rsp(A_FREE_IDX, ST_OK, H_ZERO, 1'b0);
         STEP_CLEAR_ALL:      w = rsp(A_CLEAR_ALL, ST_OK, H_ZERO, 1'b0);
         STEP_RSP_BAD_CMD:    w = rsp(A_NONE, ST_BAD_CMD, H_ZERO, 1'b0);
         STEP_RSP_BAD_PROTO:  w = rsp(A_NONE, ST_BAD_PROTO, H_ZERO, 1'b0);
         STEP_RSP_BAD_HANDLE: w = rsp(A_NONE, ST_BAD_HANDLE, H_ZERO, 1'b0);
         default:
            w = uw(J_GOTO, C_NONE, STEP_IDLE, 1'b0, A_NONE, 1'b0, ST_OK, H_ZERO, 1'b0);
      endcase
      return w;
   endfunction

   // Entry step for each request function.
   function automatic pc_type dispatch_rom(func_type func);
      pc_type pc;
      case (func)
         FN_REGISTER:   pc = STEP_REG_CHK;
         FN_UNREGISTER: pc = STEP_UNREG_CHK;
         FN_CHECK:      pc = STEP_CHECK_CHK;
         FN_CLOSE:      pc = STEP_CLOSE_SCAN;
         FN_CLEAR_ALL:  pc = STEP_CLEAR_ALL;
         default:       pc = STEP_RSP_BAD_CMD;
      endcase
      return pc;
   endfunction

endpackage

// File: src/sreg_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module sreg_seq
   import sreg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   input  func_type  func,
   output ctl_type   ctl
);

   pc_type       pc_ff;
   pc_type       pc_in;
   ctl_word_type word;
   logic         cond_hit;

   // Fetch the control word for the current step.
   assign word = ucode_rom(pc_ff);

   // Select the condition that the step tests.
   always_comb begin
      case (word.cond)
         C_NOT_START:  cond_hit = flags.not_start;
         C_BAD_PROTO:  cond_hit = flags.bad_proto;
         C_BAD_HANDLE: cond_hit = flags.bad_handle;
         C_MATCH:      cond_hit = flags.match;
         C_NO_FREE:    cond_hit = flags.no_free;
         default:      cond_hit = 1'b0;
      endcase
   end

   // Work out the next step. A scanning step stays put until a hit or the last slot.
   always_comb begin
      case (word.jmp)
         J_NEXT:     pc_in = pc_ff + PC_W'(1);
         J_GOTO:     pc_in = word.target;
         J_COND:     pc_in = cond_hit ? word.target : pc_ff + PC_W'(1);
         J_SCAN: begin
            if (cond_hit) begin
               pc_in = word.target;
            end else if (flags.last) begin
               pc_in = pc_ff + PC_W'(1);
            end else begin
               pc_in = pc_ff;
            end
         end
         J_DISPATCH: pc_in = dispatch_rom(func);
         default:    pc_in = STEP_IDLE;
      endcase
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctl.pc      = pc_ff;
   assign ctl.word    = word;
   assign ctl.idx_inc = (word.jmp == J_SCAN) && !cond_hit && !flags.last;

endmodule

// File: src/session_registration_table.sv
// Session registration table: a microcoded sequencer over a slot table with valid bits.
// Clear-all and unknown functions give their result straight after dispatch, unregister and check
// after the handle test; close and register scan the socket memory one slot per cycle. busy falls
// with the strobe, so a new item may be started in the strobe cycle; the receiver cannot stall.
// Reset empties the table and sets the supported protocol version to 1.
module session_registration_table
   import sreg_pkg::*;
#(
   parameter int SESSIONS = SESSIONS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SOCK_W-1:0]   req_socket_id,
   input  logic [HANDLE_W-1:0] req_session_handle,
   input  logic [VER_W-1:0]    req_protocol_version,
   input  logic [OPTS_W-1:0]   req_option_flags,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [HOUT_W-1:0]   rsp_handle_out,
   output logic                rsp_session_open,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [VER_W-1:0]    csr_wdata
);

   localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

   ctl_type   ctl;
   flags_type flags;

   // Captured request item.
   func_type            func_ff;
   logic [SOCK_W-1:0]   sock_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [VER_W-1:0]    ver_ff;
   logic [OPTS_W-1:0]   opts_ff;

   // Configuration register.
   logic [VER_W-1:0]    cfg_ver_ff;

   // Slot table.
   logic [SESSIONS-1:0] valid_ff;
   logic [SESSIONS-1:0] valid_in;
   logic [SOCK_W-1:0]   slot_socket_ff [SESSIONS];
   logic [SOCK_W-1:0]   rd_sock_ff;

   // Scan index and lowest free slot.
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    idx_in;
   logic [IDX_W-1:0]    free_idx_ff;
   logic                free_found_ff;
   logic [IDX_W-1:0]    hidx;
   logic                handle_in_range;
   logic [IDX_W:0]      idx_p1;
   logic [IDX_W:0]      free_p1;

   // Result registers.
   logic                rsp_strobe_ff;
   status_type          rsp_status_ff;
   logic [HOUT_W-1:0]   rsp_hout_ff;
   logic [HOUT_W-1:0]   hout_sel;
   logic                rsp_open_ff;

   sreg_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .func  (func_ff),
      .ctl   (ctl)
   );

   assign busy      = (ctl.pc != STEP_IDLE);
   assign csr_ready = 1'b1;

   // Configuration write.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ver_ff <= VER_W'(1);
      end else if (csr_valid && csr_ready) begin
         cfg_ver_ff <= csr_wdata;
      end
   end

   // Capture the item while idle; the accepting edge is the last one of this hold-open.
   always_ff @(posedge clock) begin
      if (!busy) begin
         func_ff   <= req_func;
         sock_ff   <= req_socket_id;
         handle_ff <= req_session_handle;
         ver_ff    <= req_protocol_version;
         opts_ff   <= req_option_flags;
      end
   end

   // Handle decoding: slot index and range test.
   assign hidx            = IDX_W'(handle_ff - HANDLE_W'(1));
   assign handle_in_range = (handle_ff != '0) && (handle_ff <= HANDLE_W'(SESSIONS));

   // Flags for the sequencer.
   assign flags.not_start  = !start;
   assign flags.bad_proto  = (ver_ff == '0) || (ver_ff > cfg_ver_ff) || (opts_ff != '0);
   assign flags.bad_handle = !handle_in_range || !valid_ff[hidx];
   assign flags.match      = valid_ff[idx_ff] && (rd_sock_ff == sock_ff);
   assign flags.no_free    = !free_found_ff;
   assign flags.last       = (idx_ff == IDX_W'(SESSIONS - 1));

   // Scan index: cleared while idle, stepped by scanning steps.
   always_comb begin
      if (ctl.word.clr) begin
         idx_in = '0;
      end else if (ctl.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (ctl.word.clr) begin
            free_found_ff <= 1'b0;
         end else if (ctl.word.act == A_NOTE_FREE && !valid_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   // The lowest free slot seen in the register scan.
   always_ff @(posedge clock) begin
      if (ctl.word.act == A_NOTE_FREE && !valid_ff[idx_ff] && !free_found_ff) begin
         free_idx_ff <= idx_ff;
      end
   end

   // Valid bits.
   always_comb begin
      valid_in = valid_ff;
      case (ctl.word.act)
         A_WRITE:       valid_in[free_idx_ff] = 1'b1;
         A_FREE_IDX:    valid_in[idx_ff]      = 1'b0;
         A_FREE_HANDLE: valid_in[hidx]        = 1'b0;
         A_CLEAR_ALL:   valid_in              = '0;
         default:       valid_in              = valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Socket memory: one write port, one registered read that follows the scan index.
   always_ff @(posedge clock) begin
      if (ctl.word.act == A_WRITE) begin
         slot_socket_ff[free_idx_ff] <= sock_ff;
      end
      rd_sock_ff <= slot_socket_ff[idx_in];
   end

   // Handle for the result.
   assign idx_p1  = {1'b0, idx_ff} + (IDX_W + 1)'(1);
   assign free_p1 = {1'b0, free_idx_ff} + (IDX_W + 1)'(1);

   always_comb begin
      case (ctl.word.hsel)
         H_IDX:   hout_sel = HOUT_W'(idx_p1);
         H_FREE:  hout_sel = HOUT_W'(free_p1);
         default: hout_sel = '0;
      endcase
   end

   // Result registers, shown for one cycle after a result step.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.word.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.word.emit) begin
         rsp_status_ff <= ctl.word.status;
         rsp_hout_ff   <= hout_sel;
         rsp_open_ff   <= ctl.word.sopen;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_handle_out   = rsp_hout_ff;
   assign rsp_session_open = rsp_open_ff;

   // Every result step returns to idle, so a result is never shown while busy.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // An accepted item starts the program.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not start the sequencer");

   // A slot is only written after the scan has found a free one.
   assert property (@(posedge clock) disable iff (reset)
                    (ctl.word.act == A_WRITE) |-> free_found_ff)
      else $error("slot written without a free slot");

   // An open session is only reported with a success status.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_strobe && rsp_session_open) |-> (rsp_status == ST_OK))
      else $error("open session reported with a failing status");

endmodule
